### design/ppm_pkg.sv
// Shared types and codes for the PPM stream parser.
// Depends on nothing; imported by the front end, queue, back end and top level.
package ppm_pkg;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_MAGIC  = 3'd0;
  localparam logic [2:0] ERR_FORMAT = 3'd1;
  localparam logic [2:0] ERR_PROPS  = 3'd2;
  localparam logic [2:0] ERR_EARLY  = 3'd3;
  localparam logic [2:0] ERR_BODY   = 3'd4;

  typedef enum logic [1:0] {
    TK_HDR,
    TK_CHAN,
    TK_ERR
  } tok_kind_e;

  // One classified item from the front end to the back end.
  typedef struct packed {
    tok_kind_e   kind;
    logic [15:0] value;      // channel sample, or maxval on a header
    logic [15:0] width;
    logic [15:0] height;
    logic [1:0]  pos;        // channel position within the pixel
    logic        last_pix;
    logic [2:0]  code;
  } tok_t;

endpackage

### design/ppm_stream_parser_unit.sv
// Top level of the PPM (P3/P6) stream parser.
// Depends on ppm_pkg, ppm_front, ppm_fifo and ppm_back.
//
// Bytes of a PPM file go in one per push; each yields zero or one result
// (header, RGB pixel or error code). The front end takes one byte per cycle
// while its two-entry token queue has room. Bytes that finish no channel and
// raise no result never reach the back end; header and error tokens are
// handled there in its idle state. Every body channel runs through an 8-step
// restoring divider (channel*255/maxval, or channel divided by (maxval+1)/256
// for 16-bit samples) before the back end takes its next token.
// A result waits in the output register until popped, while the front end
// keeps taking bytes until the token queue fills.
module ppm_stream_parser_unit #(
  parameter int DIM_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic        last_pixel_o,
  output logic [2:0]  error_code_o
);
  import ppm_pkg::*;

  tok_t tok_w, tok_r;
  logic tok_vld, q_full, q_empty, q_rd, acc;

  assign full = q_full;
  assign acc  = push && !q_full;

  ppm_front #(.DIM_BITS(DIM_BITS)) u_front (
    .clk_i, .rst_ni, .acc_i(acc), .data_byte_i, .first_byte_i, .last_byte_i,
    .tok_vld_o(tok_vld), .tok_o(tok_w)
  );

  ppm_fifo u_fifo (
    .clk_i, .rst_ni, .wr_i(tok_vld), .wdata_i(tok_w), .rd_i(q_rd),
    .rdata_o(tok_r), .full_o(q_full), .empty_o(q_empty)
  );

  ppm_back u_back (
    .clk_i, .rst_ni, .tok_i(tok_r), .tok_empty_i(q_empty), .tok_rd_o(q_rd),
    .pop, .empty, .kind_o, .red_o, .green_o, .blue_o, .image_width_o,
    .image_height_o, .last_pixel_o, .error_code_o
  );

endmodule

### design/ppm_front.sv
// Front end of the PPM stream parser: header and body tokenizer.
// Depends on ppm_pkg; emits at most one token per accepted byte.
module ppm_front #(
  parameter int DIM_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_i,
  input  logic [7:0]    data_byte_i,
  input  logic          first_byte_i,
  input  logic          last_byte_i,
  output logic          tok_vld_o,
  output ppm_pkg::tok_t tok_o
);
  import ppm_pkg::*;

  localparam int LimBits = (DIM_BITS >= 16) ? 16 : DIM_BITS;
  localparam logic [16:0] DimLimit = 17'((64'd1 << LimBits) - 64'd1);
  localparam logic [16:0] AccSat = 17'h1FFFF;

  typedef enum logic [2:0] {
    PH_MAGIC_P, PH_MAGIC_NUM, PH_HDR_SKIP, PH_HDR_NUM,
    PH_P3_SKIP, PH_P3_NUM, PH_RAW, PH_DONE
  } phase_e;

  phase_e      ph_q, ph_d, ph_c;
  logic        raw_q, raw_d, raw_c;
  logic        wide_q, wide_d, wide_c;
  logic [15:0] wid_q, wid_d, wid_c;
  logic [15:0] hgt_q, hgt_d, hgt_c;
  logic [16:0] acc_q, acc_d, acc_c;
  logic        cmt_q, cmt_d, cmt_c;
  logic [7:0]  hi_q, hi_d, hi_c;
  logic [1:0]  chan_q, chan_d, chan_c;
  logic [31:0] left_q, left_d, left_c;
  logic [1:0]  fld_q, fld_d, fld_c;
  logic        fok_q, fok_d, fok_c;
  logic        hh_q, hh_d, hh_c;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic [16:0] accum(input logic [16:0] a, input logic [7:0] b);
    logic [20:0] v;
    v = {a, 3'b000} + {3'b000, a, 1'b0} + {17'd0, 4'(b - "0")};
    return (v > 21'(AccSat)) ? AccSat : v[16:0];
  endfunction

  logic        do_sep, do_put, fail_en;
  logic [2:0]  fail_code;
  logic [15:0] put_val;
  logic [16:0] lim;
  tok_t        tok;

  always_comb begin
    if (first_byte_i) begin
      ph_c = PH_MAGIC_P; raw_c = 1'b0; wide_c = 1'b0; wid_c = '0; hgt_c = '0;
      acc_c = '0; cmt_c = 1'b0; hi_c = '0; chan_c = '0; left_c = '0;
      fld_c = '0; fok_c = 1'b0; hh_c = 1'b0;
    end else begin
      ph_c = ph_q; raw_c = raw_q; wide_c = wide_q; wid_c = wid_q; hgt_c = hgt_q;
      acc_c = acc_q; cmt_c = cmt_q; hi_c = hi_q; chan_c = chan_q; left_c = left_q;
      fld_c = fld_q; fok_c = fok_q; hh_c = hh_q;
    end
    ph_d = ph_c; raw_d = raw_c; wide_d = wide_c; wid_d = wid_c; hgt_d = hgt_c;
    acc_d = acc_c; cmt_d = cmt_c; hi_d = hi_c; chan_d = chan_c; left_d = left_c;
    fld_d = fld_c; fok_d = fok_c; hh_d = hh_c;
    tok = '0;
    tok.kind = TK_ERR;
    tok_vld_o = 1'b0;
    do_sep = 1'b0;
    do_put = 1'b0;
    fail_en = 1'b0;
    fail_code = ERR_MAGIC;
    put_val = '0;
    lim = (fld_c < 2'd2) ? DimLimit : 17'hFFFF;

    if (acc_i && ph_c != PH_DONE) begin
      unique case (ph_c)
        PH_MAGIC_P: begin
          if (data_byte_i != "P") begin
            fail_en = 1'b1; fail_code = ERR_MAGIC;
          end else begin
            ph_d = PH_MAGIC_NUM;
          end
        end
        PH_MAGIC_NUM: begin
          if (!is_digit(data_byte_i)) begin
            fail_en = 1'b1; fail_code = ERR_MAGIC;
          end else begin
            raw_d = (data_byte_i == "6");
            fok_d = (data_byte_i == "3") || (data_byte_i == "6");
            fld_d = '0;
            cmt_d = 1'b0;
            ph_d = PH_HDR_SKIP;
          end
        end
        PH_HDR_SKIP: do_sep = 1'b1;
        PH_HDR_NUM: begin
          if (is_digit(data_byte_i)) begin
            acc_d = accum(acc_c, data_byte_i);
          end else begin
            acc_d = '0;
            if (acc_c == '0 || acc_c > lim) begin
              fail_en = 1'b1; fail_code = ERR_PROPS;
            end else if (fld_c == 2'd0) begin
              wid_d = acc_c[15:0]; fld_d = 2'd1; ph_d = PH_HDR_SKIP; do_sep = 1'b1;
            end else if (fld_c == 2'd1) begin
              hgt_d = acc_c[15:0]; fld_d = 2'd2; ph_d = PH_HDR_SKIP; do_sep = 1'b1;
            end else if (!is_ws(data_byte_i)) begin
              fail_en = 1'b1; fail_code = ERR_PROPS;
            end else if (!fok_c) begin
              fail_en = 1'b1; fail_code = ERR_FORMAT;
            end else begin
              left_d = wid_c * hgt_c;
              wide_d = (acc_c > 17'd255);
              chan_d = '0;
              hh_d = 1'b0;
              ph_d = raw_c ? PH_RAW : PH_P3_SKIP;
              tok.kind = TK_HDR;
              tok.value = acc_c[15:0];
              tok.width = wid_c;
              tok.height = hgt_c;
              tok_vld_o = 1'b1;
            end
          end
        end
        PH_P3_SKIP: begin
          if (is_digit(data_byte_i)) begin
            acc_d = accum(17'd0, data_byte_i);
            ph_d = PH_P3_NUM;
          end else if (!is_ws(data_byte_i)) begin
            fail_en = 1'b1; fail_code = ERR_BODY;
          end
        end
        PH_P3_NUM: begin
          if (is_digit(data_byte_i)) begin
            acc_d = accum(acc_c, data_byte_i);
          end else if (!is_ws(data_byte_i)) begin
            fail_en = 1'b1; fail_code = ERR_BODY;
          end else begin
            acc_d = '0;
            ph_d = PH_P3_SKIP;
            if (acc_c > 17'hFFFF) begin
              fail_en = 1'b1; fail_code = ERR_BODY;
            end else begin
              do_put = 1'b1; put_val = acc_c[15:0];
            end
          end
        end
        PH_RAW: begin
          if (wide_c && !hh_c) begin
            hi_d = data_byte_i; hh_d = 1'b1;
          end else begin
            hh_d = 1'b0;
            do_put = 1'b1;
            put_val = wide_c ? {hi_c, data_byte_i} : {8'd0, data_byte_i};
          end
        end
        default: ;
      endcase

      // separator between header numbers
      if (do_sep) begin
        if (cmt_c) begin
          if (data_byte_i == 8'd10) cmt_d = 1'b0;
        end else if (is_ws(data_byte_i)) begin
          cmt_d = cmt_c;
        end else if (data_byte_i == "#") begin
          cmt_d = 1'b1;
        end else if (is_digit(data_byte_i)) begin
          acc_d = accum(17'd0, data_byte_i);
          ph_d = PH_HDR_NUM;
        end else begin
          fail_en = 1'b1; fail_code = ERR_PROPS;
        end
      end

      // a final digit closes its channel
      if (last_byte_i && !fail_en && !do_put && ph_d == PH_P3_NUM) begin
        ph_d = PH_P3_SKIP;
        if (acc_d > 17'hFFFF) begin
          fail_en = 1'b1; fail_code = ERR_BODY;
        end else begin
          do_put = 1'b1; put_val = acc_d[15:0];
        end
        acc_d = '0;
      end

      if (do_put && !fail_en) begin
        tok.kind = TK_CHAN;
        tok.value = put_val;
        tok.pos = chan_c;
        tok_vld_o = 1'b1;
        if (chan_c < 2'd2) begin
          chan_d = chan_c + 2'd1;
        end else begin
          chan_d = '0;
          if (left_c != '0) left_d = left_c - 32'd1;
          if (left_d == '0) begin
            tok.last_pix = 1'b1;
            ph_d = PH_DONE;
          end
        end
      end

      if (fail_en) begin
        ph_d = PH_DONE;
        tok = '0;
        tok.kind = TK_ERR;
        tok.code = fail_code;
        tok_vld_o = 1'b1;
      end

      if (last_byte_i && ph_d != PH_DONE) begin
        tok = '0;
        tok.kind = TK_ERR;
        tok.code = ERR_EARLY;
        tok_vld_o = 1'b1;
      end
      if (last_byte_i) ph_d = PH_DONE;
    end
  end

  assign tok_o = tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_MAGIC_P; raw_q <= 1'b0; wide_q <= 1'b0; wid_q <= '0; hgt_q <= '0;
      acc_q <= '0; cmt_q <= 1'b0; hi_q <= '0; chan_q <= '0; left_q <= '0;
      fld_q <= '0; fok_q <= 1'b0; hh_q <= 1'b0;
    end else if (acc_i) begin
      ph_q <= ph_d; raw_q <= raw_d; wide_q <= wide_d; wid_q <= wid_d; hgt_q <= hgt_d;
      acc_q <= acc_d; cmt_q <= cmt_d; hi_q <= hi_d; chan_q <= chan_d; left_q <= left_d;
      fld_q <= fld_d; fok_q <= fok_d; hh_q <= hh_d;
    end
  end

  // tokens only come out of an accepted byte
  assert property (@(posedge clk_i) disable iff (!rst_ni) tok_vld_o |-> acc_i)
    else $error("front token without accepted byte");

endmodule

### design/ppm_fifo.sv
// Two-entry token queue between the parser front end and the back end.
// Depends on ppm_pkg for the token type.
module ppm_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  ppm_pkg::tok_t wdata_i,
  input  logic          rd_i,
  output ppm_pkg::tok_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);
  import ppm_pkg::*;

  tok_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr_i && !full_o) wp_q <= ~wp_q;
      if (rd_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'((wr_i && !full_o) ? 1 : 0) - 2'((rd_i && !empty_o) ? 1 : 0);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("token queue count out of range");

endmodule

### design/ppm_back.sv
// Back end of the PPM stream parser: channel scaling and pixel assembly.
// Depends on ppm_pkg; scales with an 8-step restoring divider, one bit a cycle.
module ppm_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ppm_pkg::tok_t tok_i,
  input  logic          tok_empty_i,
  output logic          tok_rd_o,
  input  logic          pop,
  output logic          empty,
  output logic [1:0]    kind_o,
  output logic [7:0]    red_o,
  output logic [7:0]    green_o,
  output logic [7:0]    blue_o,
  output logic [15:0]   image_width_o,
  output logic [15:0]   image_height_o,
  output logic          last_pixel_o,
  output logic [2:0]    error_code_o
);
  import ppm_pkg::*;

  typedef enum logic {S_IDLE, S_DIV} st_e;

  st_e         st_q;
  logic        ov_q;
  logic [1:0]  kind_q;
  logic [7:0]  r_q, g_q, b_q, pr_q, pg_q, q_q;
  logic [15:0] w_q, h_q, maxv_q;
  logic        lp_q, plast_q, sat_q;
  logic [2:0]  code_q, cnt_q;
  logic [1:0]  pos_q;
  logic [23:0] rem_q;
  logic [8:0]  div_q;

  logic        out_free, ov_set;
  logic [23:0] num, sub;
  logic [8:0]  den;
  logic        bit_set;
  logic [7:0]  q_fin, val;

  assign out_free = !ov_q || pop;
  assign tok_rd_o = (st_q == S_IDLE) && !tok_empty_i && out_free;
  assign empty = !ov_q;

  // a result lands on a header or error token, or when the third channel finishes
  assign ov_set = (st_q == S_IDLE) ? (tok_rd_o && tok_i.kind != TK_CHAN)
                                   : (cnt_q == 3'd0 && pos_q == 2'd2);

  always_comb begin
    if (maxv_q > 16'd255) begin
      num = {8'd0, tok_i.value};
      den = 9'((17'(maxv_q) + 17'd1) >> 8);
    end else begin
      num = {tok_i.value, 8'd0} - {8'd0, tok_i.value};
      den = maxv_q[8:0];
    end
  end

  assign sub     = 24'(div_q) << cnt_q;
  assign bit_set = (rem_q >= sub);
  assign q_fin   = q_q | (8'(bit_set) << cnt_q);
  assign val     = sat_q ? 8'd255 : q_fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
      maxv_q <= '0;
    end else begin
      ov_q <= ov_set || (ov_q && !pop);
      unique case (st_q)
        S_IDLE: begin
          if (tok_rd_o) begin
            unique case (tok_i.kind)
              TK_HDR: begin
                maxv_q <= tok_i.value;
                kind_q <= KIND_HEADER;
                w_q <= tok_i.width; h_q <= tok_i.height;
                r_q <= '0; g_q <= '0; b_q <= '0; lp_q <= 1'b0; code_q <= '0;
              end
              TK_ERR: begin
                kind_q <= KIND_ERROR;
                code_q <= tok_i.code;
                w_q <= '0; h_q <= '0;
                r_q <= '0; g_q <= '0; b_q <= '0; lp_q <= 1'b0;
              end
              default: begin
                rem_q <= num;
                div_q <= den;
                sat_q <= (num >= {7'd0, den, 8'd0});
                q_q <= '0;
                cnt_q <= 3'd7;
                pos_q <= tok_i.pos;
                plast_q <= tok_i.last_pix;
                st_q <= S_DIV;
              end
            endcase
          end
        end
        S_DIV: begin
          if (bit_set) rem_q <= rem_q - sub;
          q_q <= q_fin;
          if (cnt_q != 3'd0) begin
            cnt_q <= cnt_q - 3'd1;
          end else begin
            st_q <= S_IDLE;
            if (pos_q == 2'd0) begin
              pr_q <= val;
            end else if (pos_q == 2'd1) begin
              pg_q <= val;
            end else begin
              kind_q <= KIND_PIXEL;
              r_q <= pr_q; g_q <= pg_q; b_q <= val;
              lp_q <= plast_q;
              w_q <= '0; h_q <= '0; code_q <= '0;
            end
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign kind_o = kind_q;
  assign red_o = r_q;
  assign green_o = g_q;
  assign blue_o = b_q;
  assign image_width_o = w_q;
  assign image_height_o = h_q;
  assign last_pixel_o = lp_q;
  assign error_code_o = code_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) (st_q == S_DIV) |-> !ov_q)
    else $error("divider running while a result waits");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(ov_q) && kind_q == KIND_PIXEL) |-> $past(st_q == S_DIV))
    else $error("pixel result without a finished division");

endmodule
